// ===== rtl/core/crc8rf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crc8rf_pkg;

   // Frame geometry
   localparam int unsigned FrameLen = 4;

   // Register indexes on the csr port
   localparam logic [7:0] CSR_HEADER_BYTE = 8'd0;
   localparam logic [7:0] CSR_CRC_POLY    = 8'd1;
   localparam logic [7:0] CSR_RANGE_MIN   = 8'd2;
   localparam logic [7:0] CSR_RANGE_MAX   = 8'd3;

   // Register reset values
   localparam logic [7:0]  HEADER_RESET    = 8'h54;
   localparam logic [7:0]  POLY_RESET      = 8'h07;
   localparam logic [14:0] RANGE_MIN_RESET = 15'd200;
   localparam logic [14:0] RANGE_MAX_RESET = 15'd14000;

   // Result status codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_LIMIT    = 3'd1;
   localparam logic [2:0] STATUS_CRC      = 3'd2;
   localparam logic [2:0] STATUS_EARLY    = 3'd3;
   localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

   typedef logic [3:0][7:0] frame_type;

   typedef struct packed {
      logic [7:0]  header_byte;
      logic [7:0]  crc_polynomial;
      logic [14:0] range_min;
      logic [14:0] range_max;
   } cfg_type;

   typedef struct packed {
      logic [7:0] value;
      logic       ready;
   } crc_status_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] range_mm;
   } rsp_item_type;

   // One byte of MSB-first CRC-8, init and final XOR handled by the caller
   function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                              input logic [7:0] data,
                                              input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crc8rf_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crc8rf_csr
   import crc8rf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_data,
   output cfg_type          cfg,
   output logic             poly_wr
);

   cfg_type cfg_ff, cfg_in;
   logic    wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;
   assign poly_wr   = wr && (csr_index == CSR_CRC_POLY);

   // Register decode, low bits kept, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_index)
            CSR_HEADER_BYTE: cfg_in.header_byte    = csr_data[7:0];
            CSR_CRC_POLY:    cfg_in.crc_polynomial = csr_data[7:0];
            CSR_RANGE_MIN:   cfg_in.range_min      = csr_data[14:0];
            CSR_RANGE_MAX:   cfg_in.range_max      = csr_data[14:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte    <= HEADER_RESET;
         cfg_ff.crc_polynomial <= POLY_RESET;
         cfg_ff.range_min      <= RANGE_MIN_RESET;
         cfg_ff.range_max      <= RANGE_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/crc8rf_crc.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Running CRC over the stored frame bytes. It absorbs one stored byte per
// cycle and trails the frame store by at most one byte in steady streaming.
module crc8rf_crc
   import crc8rf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       clear,
   input  wire logic [7:0] poly,
   input  wire logic [2:0] fill_count,
   input  wire frame_type  frame_bytes,
   output crc_status_type  crc
);

   logic [7:0] crc_ff, crc_in;
   logic [1:0] done_ff, done_in;
   logic       absorb;

   // Bytes 0..2 are covered; absorb the next one once it is stored
   assign absorb = (done_ff != 2'd3) && ({1'b0, done_ff} < fill_count);

   always_comb begin
      crc_in  = crc_ff;
      done_in = done_ff;
      if (clear) begin
         crc_in  = 8'h00;
         done_in = 2'd0;
      end else if (absorb) begin
         crc_in  = crc8_update(crc_ff, frame_bytes[done_ff], poly);
         done_in = done_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= 8'h00;
         done_ff <= 2'd0;
      end else begin
         crc_ff  <= crc_in;
         done_ff <= done_in;
      end
   end

   assign crc.value = crc_ff;
   assign crc.ready = (done_ff == 2'd3);

endmodule

`default_nettype wire

// ===== rtl/core/crc8rf_rsp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-entry result queue: output register plus one skid slot
module crc8rf_rsp_queue
   import crc8rf_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  wire rsp_item_type item,
   output logic       full,
   output logic       rsp_valid,
   input  wire logic  rsp_stall,
   output rsp_item_type head
);

   rsp_item_type slot0_ff, slot0_in;
   rsp_item_type slot1_ff, slot1_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;

   // Slot movement; push never comes while full
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         if (count_ff == 2'd2) begin
            slot0_in = slot1_ff;
         end else if (push) begin
            slot0_in = item;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_in = item;
         end else begin
            slot1_in = item;
         end
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign head = slot0_ff;

endmodule

`default_nettype wire

// ===== rtl/core/crc8_range_frame_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    req_byte_in[7:0]
// rsp      out        rsp_valid/stall    rsp_status[2:0], rsp_range_mm[15:0] signed
// csr      in         csr_valid/ready    csr_index[7:0], csr_data[15:0]
//
// One byte per cycle while req_stall is low; a result is queued when its closing
// byte is accepted. The CRC is built one stored byte per cycle by a running CRC
// register. After a polynomial write it restarts over the held bytes, so a
// closing header may be stalled until bytes 0..2 are covered again. Synchronous
// reset, no clearing pass. req_stall also rises while both result slots are full.
module crc8_range_frame_parser
   import crc8rf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_byte_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic signed [15:0] rsp_range_mm,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   cfg_type        cfg;
   logic           poly_wr;
   crc_status_type crc;
   rsp_item_type   item;
   rsp_item_type   head;
   logic           q_full;

   frame_type  frame_ff, frame_in;
   logic [2:0] fill_ff, fill_in;
   logic       accept;
   logic       is_header;
   logic       frame_full;
   logic       push;
   logic       crc_wait;
   logic [15:0] range_w;
   logic       in_limits;

   crc8rf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .poly_wr   (poly_wr)
   );

   crc8rf_crc u_crc (
      .clock       (clock),
      .reset       (reset),
      .clear       (push || poly_wr),
      .poly        (cfg.crc_polynomial),
      .fill_count  (fill_ff),
      .frame_bytes (frame_ff),
      .crc         (crc)
   );

   // Input handshake
   assign frame_full = (fill_ff == 3'(FrameLen));
   assign crc_wait   = frame_full && !crc.ready;
   assign req_stall  = crc_wait || q_full;
   assign accept     = req_valid && !req_stall;
   assign is_header  = (req_byte_in == cfg.header_byte);
   assign push       = accept && (is_header || frame_full);

   // Range check, limits are exclusive
   assign range_w   = {frame_ff[1], frame_ff[2]};
   assign in_limits = ($signed(range_w) < $signed({1'b0, cfg.range_max})) &&
                      ($signed(range_w) > $signed({1'b0, cfg.range_min}));

   // Result decision
   always_comb begin
      item.range_mm = 16'h0000;
      if (!is_header) begin
         item.status = STATUS_OVERFLOW;
      end else if (!frame_full) begin
         item.status = STATUS_EARLY;
      end else if (crc.value != frame_ff[3]) begin
         item.status = STATUS_CRC;
      end else begin
         item.status   = in_limits ? STATUS_OK : STATUS_LIMIT;
         item.range_mm = range_w;
      end
   end

   // Frame store and fill count
   always_comb begin
      frame_in = frame_ff;
      fill_in  = fill_ff;
      if (push) begin
         frame_in    = '0;
         frame_in[0] = cfg.header_byte;
         fill_in     = 3'd1;
      end else if (accept) begin
         frame_in[fill_ff[1:0]] = req_byte_in;
         fill_in                = fill_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         fill_ff  <= 3'd0;
      end else begin
         frame_ff <= frame_in;
         fill_ff  <= fill_in;
      end
   end

   crc8rf_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .item      (item),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_status   = head.status;
   assign rsp_range_mm = head.range_mm;

endmodule

`default_nettype wire

// ===== rtl/core/crc8rf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crc8rf_checker
   import crc8rf_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_status,
   input wire logic [15:0] rsp_range_mm
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // No result comes out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Status code is one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STATUS_OVERFLOW))
      else $error("undefined status code");

   // Range is zero for CRC, early header and overflow results
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_CRC || rsp_status == STATUS_EARLY ||
                    rsp_status == STATUS_OVERFLOW) |-> (rsp_range_mm == 16'h0000))
      else $error("range not zero for a failed frame");

   // Lower limit is never negative, so a good range is positive
   a_ok_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OK) |-> ($signed(rsp_range_mm) > 16'sd0))
      else $error("good range not above zero");

endmodule

bind crc8_range_frame_parser crc8rf_checker u_crc8rf_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_range_mm (rsp_range_mm)
);

`default_nettype wire

// ===== tb/crc8_range_frame_parser_test.sv =====
`timescale 1ns / 1ps

module crc8_range_frame_parser_test;
   import crc8rf_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 200000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned ITEMS_PER_PHASE = 400;
   localparam int unsigned HOLD_CYCLES = 400;

   // Frame decoder predictor plus the queue of results still owed by the block
   class frame_scoreboard;
      logic [7:0]   header_byte;
      logic [7:0]   crc_poly;
      logic [14:0]  range_min;
      logic [14:0]  range_max;
      logic [2:0]   fill_count;
      logic [7:0]   frame_bytes [4];
      rsp_item_type pending_results [$];
      int           mismatches;
      int           results_seen;

      function new();
         header_byte = HEADER_RESET;
         crc_poly = POLY_RESET;
         range_min = RANGE_MIN_RESET;
         range_max = RANGE_MAX_RESET;
         fill_count = '0;
         foreach (frame_bytes[i]) frame_bytes[i] = '0;
         mismatches = 0;
         results_seen = 0;
      endfunction

      // MSB-first CRC-8 over three bytes, zero init, no final xor
      function logic [7:0] crc_of(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2);
         logic [23:0] msg;
         logic [7:0]  crc;
         msg = {b0, b1, b2};
         crc = 8'h00;
         for (int i = 0; i < 3; i++) begin
            crc = crc ^ msg[23 - 8 * i -: 8];
            for (int k = 0; k < 8; k++) begin
               if (crc[7]) crc = {crc[6:0], 1'b0} ^ crc_poly;
               else crc = {crc[6:0], 1'b0};
            end
         end
         return crc;
      endfunction

      // Register write; upper bits beyond the register width are dropped
      function void write_reg(input logic [7:0] index, input logic [15:0] data);
         case (index)
            CSR_HEADER_BYTE: header_byte = data[7:0];
            CSR_CRC_POLY:    crc_poly = data[7:0];
            CSR_RANGE_MIN:   range_min = data[14:0];
            CSR_RANGE_MAX:   range_max = data[14:0];
            default: ;
         endcase
      endfunction

      // One accepted byte: store it, or close / abort the frame
      function void note_byte(input logic [7:0] value);
         rsp_item_type item;
         int           range_val;
         if (value != header_byte && fill_count < FrameLen) begin
            frame_bytes[fill_count[1:0]] = value;
            fill_count = fill_count + 3'd1;
            return;
         end
         item.range_mm = '0;
         if (value != header_byte) begin
            item.status = STATUS_OVERFLOW;
         end else if (fill_count != FrameLen) begin
            item.status = STATUS_EARLY;
         end else if (crc_of(frame_bytes[0], frame_bytes[1], frame_bytes[2])
                      != frame_bytes[3]) begin
            item.status = STATUS_CRC;
         end else begin
            item.range_mm = {frame_bytes[1], frame_bytes[2]};
            range_val = $signed(item.range_mm);
            if (range_val > int'(range_min) && range_val < int'(range_max))
               item.status = STATUS_OK;
            else
               item.status = STATUS_LIMIT;
         end
         // restart with the header held as byte 0
         foreach (frame_bytes[i]) frame_bytes[i] = '0;
         frame_bytes[0] = header_byte;
         fill_count = 3'd1;
         pending_results.push_back(item);
      endfunction

      // One accepted result against the oldest prediction
      function void check_result(input logic [2:0] status, input logic [15:0] range_mm);
         rsp_item_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: status %0d range %0d with nothing pending",
                        results_seen, status, $signed(range_mm));
            return;
         end
         want = pending_results.pop_front();
         if (status !== want.status || range_mm !== want.range_mm) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: status %0d range %0d, expected status %0d range %0d",
                        results_seen, status, $signed(range_mm), want.status,
                        $signed(want.range_mm));
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_byte_in = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_status;
   logic signed [15:0] rsp_range_mm;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_index = 8'h00;
   logic [15:0]        csr_data = 16'h0000;

   frame_scoreboard    frame_sb;
   int unsigned        send_idle_pct = 21;
   int unsigned        recv_idle_pct = 60;
   int unsigned        hold_left = 0;
   int unsigned        cycle_count = 0;

   crc8_range_frame_parser DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_byte_in  (req_byte_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_range_mm (rsp_range_mm),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Receiver: random stall, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Monitor every transfer on all three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) frame_sb.write_reg(csr_index, csr_data);
         if (req_valid && !req_stall) frame_sb.note_byte(req_byte_in);
         if (rsp_valid && !rsp_stall) frame_sb.check_result(rsp_status, rsp_range_mm);
      end
   end

   // One byte transfer, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // Range bytes, CRC (optionally corrupted), then the closing header
   task automatic send_frame(input logic [15:0] range_bits, input bit good_crc);
      logic [7:0] crc;
      crc = frame_sb.crc_of(frame_sb.header_byte, range_bits[15:8], range_bits[7:0]);
      if (!good_crc) crc = crc ^ 8'($urandom_range(1, 255));
      send_byte(range_bits[15:8]);
      send_byte(range_bits[7:0]);
      send_byte(crc);
      send_byte(frame_sb.header_byte);
   endtask

   task automatic csr_write(input logic [7:0] index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // All four registers, with junk above each register's width
   task automatic configure(input logic [7:0] hdr, input logic [7:0] poly,
                            input logic [14:0] rmin, input logic [14:0] rmax);
      csr_write(CSR_HEADER_BYTE, {8'($urandom), hdr});
      csr_write(CSR_CRC_POLY, {8'($urandom), poly});
      csr_write(CSR_RANGE_MIN, {1'($urandom), rmin});
      csr_write(CSR_RANGE_MAX, {1'($urandom), rmax});
   endtask

   // Wait for every owed result, then let in-flight CRC work settle.
   // The first edge lets the monitor log the last byte transfer.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Range values: half around the limits and the 16-bit extremes, half random
   function automatic logic [15:0] pick_range();
      int offset;
      offset = int'($urandom_range(0, 2)) - 1;
      case ($urandom_range(0, 5))
         0: return 16'(int'(frame_sb.range_min) + offset);
         1: return 16'(int'(frame_sb.range_max) + offset);
         2: begin
            case ($urandom_range(0, 3))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly well-formed frames, the rest short/long frames, noise, lone headers
   task automatic run_traffic(input int unsigned n_bytes);
      int unsigned sent;
      int unsigned kind;
      int unsigned len;
      sent = 0;
      while (sent < n_bytes) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            send_frame(pick_range(), $urandom_range(0, 99) < 85);
            sent += 4;
         end else if (kind < 82) begin
            len = $urandom_range(0, 6);
            repeat (len) send_byte(8'($urandom));
            send_byte(frame_sb.header_byte);
            sent += len + 1;
         end else if (kind < 94) begin
            len = $urandom_range(1, 8);
            repeat (len) send_byte(8'($urandom));
            sent += len;
         end else begin
            send_byte(frame_sb.header_byte);
            sent += 1;
         end
      end
   endtask

   initial begin
      int unsigned  rmin;
      logic         failed;
      frame_sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset configuration.
      // Bytes before any header form a frame whose byte 0 is not compared with the header byte.
      send_byte(8'h11);
      send_byte(8'h01);
      send_byte(8'h00);
      send_byte(frame_sb.crc_of(8'h11, 8'h01, 8'h00));
      send_byte(HEADER_RESET);
      send_frame(16'd1000, 1'b1);
      send_frame(16'd200, 1'b1);
      send_frame(16'd14000, 1'b1);
      send_frame(16'h8000, 1'b1);
      send_frame(16'd5000, 1'b0);
      // four bytes held, then a fifth data byte overflows
      send_byte(8'h03);
      send_byte(8'hE8);
      send_byte(8'h00);
      send_byte(8'hFF);
      // header with only byte 0 held
      send_byte(HEADER_RESET);
      drain();

      // Random phases with different idling and register settings
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 21;
               recv_idle_pct = 60;
               configure(HEADER_RESET, POLY_RESET, RANGE_MIN_RESET, RANGE_MAX_RESET);
            end
            1: begin
               send_idle_pct = 60;
               recv_idle_pct = 21;
               configure(8'h00, 8'hFF, 15'd0, 15'h7FFF);
            end
            2: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               configure(8'hFF, 8'h00, 15'($urandom_range(0, 16000)), 15'h7FFF);
               csr_write(8'($urandom_range(4, 255)), 16'($urandom));
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               rmin = $urandom_range(0, 16000);
               configure(8'($urandom), 8'($urandom), 15'(rmin),
                         15'(rmin + $urandom_range(1, 32767 - rmin)));
            end
         endcase
         if (phase == 2) begin
            // receiver holds off while frames keep coming, filling the result slots
            hold_left = HOLD_CYCLES;
            repeat (15) send_frame(pick_range(), 1'b1);
         end
         run_traffic(ITEMS_PER_PHASE);
         drain();
      end

      failed = (frame_sb.mismatches != 0) || (frame_sb.pending_results.size() != 0);
      if (!failed) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/crc8rf_pkg.sv
rtl/core/crc8rf_csr.sv
rtl/core/crc8rf_crc.sv
rtl/core/crc8rf_rsp_queue.sv
rtl/core/crc8_range_frame_parser.sv
rtl/core/crc8rf_checker.sv
tb/crc8_range_frame_parser_test.sv
